// File: rtl/receive_line_assembler_top_defines.svh
// ----------------------------------------------------------------------------
// receive line assembler assertion macros
// shared concurrent assertion forms for the block's checker
// ----------------------------------------------------------------------------
`ifndef RECEIVE_LINE_ASSEMBLER_TOP_DEFINES_SVH
`define RECEIVE_LINE_ASSEMBLER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RLA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("receive line assembler check failed");

// next-cycle implication, disabled while reset is asserted
`define RLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("receive line assembler check failed");

`endif

// File: rtl/rla_pkg.sv
// ----------------------------------------------------------------------------
// rla_pkg
// shared types and constants of the receive line assembler
// ----------------------------------------------------------------------------
`default_nettype none

package rla_pkg;

    // default geometry
    localparam int BUFFER_DEPTH_DEF   = 256;
    localparam int LINE_LIMIT_MAX_DEF = 64;

    // register and field widths
    localparam int LIMIT_W = 7;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;

    localparam logic [LIMIT_W-1:0] LINE_LIMIT_RESET = 7'd64;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_TAKE   = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

    // line break characters
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    // one result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] line_char;
        logic              last;
    } t_result;

    // load request from the walker into the output stage
    typedef struct packed {
        logic    load;
        t_result res;
    } t_out_req;

endpackage

`default_nettype wire

// File: rtl/rla_ram.sv
// ----------------------------------------------------------------------------
// rla_ram
// generic single-clock ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/rla_walk.sv
// ----------------------------------------------------------------------------
// rla_walk
// buffer bookkeeping and line walker over the byte store
// ----------------------------------------------------------------------------
`default_nettype none

module rla_walk #(
    parameter int BUFFER_DEPTH   = rla_pkg::BUFFER_DEPTH_DEF,
    parameter int LINE_LIMIT_MAX = rla_pkg::LINE_LIMIT_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input items
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [rla_pkg::OP_W-1:0]        i_op,
    input  wire logic [rla_pkg::BYTE_W-1:0]      i_data,
    // line limit register write
    input  wire logic                            i_cfg_valid,
    input  wire logic [rla_pkg::LIMIT_W-1:0]     i_cfg_data,
    // byte store
    output logic                                 o_ram_we,
    output logic      [$clog2(BUFFER_DEPTH)-1:0] o_ram_waddr,
    output logic      [rla_pkg::BYTE_W-1:0]      o_ram_wdata,
    output logic                                 o_ram_re,
    output logic      [$clog2(BUFFER_DEPTH)-1:0] o_ram_raddr,
    input  wire logic [rla_pkg::BYTE_W-1:0]      i_ram_rdata,
    // output stage
    output rla_pkg::t_out_req                    o_req,
    input  wire logic                            i_out_free
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int EMIT_W = $clog2(LINE_LIMIT_MAX);
    localparam int SUM_W  = CNT_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_EV   = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // control state
    logic [1:0]                   r_state, n_state;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [ADDR_W-1:0]            r_start, n_start;
    logic [CNT_W-1:0]             r_brk, n_brk;
    logic [rla_pkg::LIMIT_W-1:0]  r_limit;
    // walk state
    logic [CNT_W-1:0]             r_idx, n_idx;
    logic [ADDR_W-1:0]            r_addr, n_addr;
    logic [EMIT_W-1:0]            r_emitted, n_emitted;
    logic                         r_started, n_started;
    logic                         r_ended, n_ended;
    logic [CNT_W-1:0]             r_brk_seen, n_brk_seen;

    logic [rla_pkg::LIMIT_W-1:0]  limit_eff;
    logic [SUM_W-1:0]             wr_sum;
    logic [ADDR_W-1:0]            wr_addr;
    logic [ADDR_W-1:0]            addr_next;
    logic                         in_brk;
    logic                         rd_brk;
    logic                         full;
    logic                         in_accept;
    logic                         can_emit;

    // effective limit, tail address, next walk address
    assign limit_eff = (r_limit > rla_pkg::LIMIT_W'(LINE_LIMIT_MAX)) ?
                       rla_pkg::LIMIT_W'(LINE_LIMIT_MAX) : r_limit;
    assign wr_sum    = SUM_W'(r_start) + SUM_W'(r_count);
    assign wr_addr   = (wr_sum >= SUM_W'(BUFFER_DEPTH)) ?
                       ADDR_W'(wr_sum - SUM_W'(BUFFER_DEPTH)) : ADDR_W'(wr_sum);
    assign addr_next = (r_addr == ADDR_W'(BUFFER_DEPTH - 1)) ? '0 : r_addr + 1'b1;
    assign in_brk    = (i_data == rla_pkg::CHAR_CR) || (i_data == rla_pkg::CHAR_LF);
    assign rd_brk    = (i_ram_rdata == rla_pkg::CHAR_CR) ||
                       (i_ram_rdata == rla_pkg::CHAR_LF);
    assign full      = (r_count == CNT_W'(BUFFER_DEPTH));
    assign can_emit  = ((8'(r_emitted) + 8'd1) < {1'b0, limit_eff});

    assign o_in_ready = (r_state == ST_IDLE) && i_out_free;
    assign in_accept  = i_in_valid && o_in_ready;

    assign o_ram_waddr = wr_addr;
    assign o_ram_wdata = i_data;
    assign o_ram_raddr = r_addr;

    // next-state logic
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_start    = r_start;
        n_brk      = r_brk;
        n_idx      = r_idx;
        n_addr     = r_addr;
        n_emitted  = r_emitted;
        n_started  = r_started;
        n_ended    = r_ended;
        n_brk_seen = r_brk_seen;
        o_ram_we   = 1'b0;
        o_ram_re   = 1'b0;
        o_req      = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    case (i_op)
                        rla_pkg::OP_APPEND: begin
                            // a byte for a full store is dropped
                            if (!full) begin
                                o_ram_we = 1'b1;
                                n_count  = r_count + 1'b1;
                                if (in_brk) begin
                                    n_brk = r_brk + 1'b1;
                                end
                            end
                        end
                        rla_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_start = '0;
                            n_brk   = '0;
                        end
                        rla_pkg::OP_TAKE: begin
                            if ((limit_eff == '0) || (r_count == '0) ||
                                ((r_brk == '0) && !full)) begin
                                // zero limit, or no complete line held
                                o_req.load          = 1'b1;
                                o_req.res.kind      = rla_pkg::KIND_NONE;
                                o_req.res.line_char = '0;
                                o_req.res.last      = 1'b1;
                            end else begin
                                n_idx      = '0;
                                n_addr     = r_start;
                                n_emitted  = '0;
                                n_started  = 1'b0;
                                n_ended    = 1'b0;
                                n_brk_seen = '0;
                                n_state    = ST_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD: begin
                // read the next held byte, or finish at the end of the held bytes
                if (r_idx == r_count) begin
                    n_state = ST_DONE;
                end else begin
                    o_ram_re = 1'b1;
                    n_state  = ST_EV;
                end
            end
            ST_EV: begin
                if (rd_brk) begin
                    // break: consumed, ends the line once characters began
                    n_ended    = r_ended | r_started;
                    n_brk_seen = r_brk_seen + 1'b1;
                    n_idx      = r_idx + 1'b1;
                    n_addr     = addr_next;
                    n_state    = ST_RD;
                end else if (r_ended) begin
                    // first character of the following line stays held
                    n_state = ST_DONE;
                end else if (can_emit) begin
                    if (i_out_free) begin
                        o_req.load          = 1'b1;
                        o_req.res.kind      = rla_pkg::KIND_CHAR;
                        o_req.res.line_char = i_ram_rdata;
                        o_req.res.last      = 1'b0;
                        n_started           = 1'b1;
                        n_emitted           = r_emitted + 1'b1;
                        n_idx               = r_idx + 1'b1;
                        n_addr              = addr_next;
                        n_state             = ST_RD;
                    end
                end else begin
                    // over the limit: consumed and discarded
                    n_started = 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_addr    = addr_next;
                    n_state   = ST_RD;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_req.load          = 1'b1;
                    o_req.res.kind      = rla_pkg::KIND_DONE;
                    o_req.res.line_char = '0;
                    o_req.res.last      = 1'b1;
                    n_count             = r_count - r_idx;
                    n_start             = (r_count == r_idx) ? '0 : r_addr;
                    n_brk               = r_brk - r_brk_seen;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_start <= '0;
            r_brk   <= '0;
            r_limit <= rla_pkg::LINE_LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_start <= n_start;
            r_brk   <= n_brk;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // walk registers, set up at the start of each take
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_addr     <= n_addr;
        r_emitted  <= n_emitted;
        r_started  <= n_started;
        r_ended    <= n_ended;
        r_brk_seen <= n_brk_seen;
    end

endmodule

`default_nettype wire

// File: rtl/rla_out_reg.sv
// ----------------------------------------------------------------------------
// rla_out_reg
// output register stage for result items
// ----------------------------------------------------------------------------
`default_nettype none

module rla_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rla_pkg::t_out_req i_req,
    output logic                   o_free,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output rla_pkg::t_result       o_res
);

    logic             r_valid;
    rla_pkg::t_result r_res;

    // the slot is free when empty or being taken this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_req.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_req.load) begin
            r_res <= i_req.res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: rtl/receive_line_assembler_top.sv
// append and clear are acted on at accept; a new item can follow in the next cycle
// take with no line held: the no-line result is loaded into the result register at accept
// take with a line: each examined byte is read from the store, then evaluated; the done
//   marker follows at the end of the held bytes or at the next line's first character,
//   plus any result stall; input is held off for the walk and while a result waits
// sync active-low reset clears count, start index and limit (to 64); store not cleared
// ----------------------------------------------------------------------------
// receive_line_assembler_top
// buffers received bytes in a circular store and hands them back a line at a time
// ----------------------------------------------------------------------------
`default_nettype none

module receive_line_assembler_top #(
    parameter int BUFFER_DEPTH   = rla_pkg::BUFFER_DEPTH_DEF,
    parameter int LINE_LIMIT_MAX = rla_pkg::LINE_LIMIT_MAX_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input items
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
    input  wire logic [1:0]                  s_axis_tuser,  // [1:0] operation
    // result items
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [7:0]                  m_axis_tdata,  // [7:0] line_char
    output logic      [1:0]                  m_axis_tuser,  // [1:0] kind
    output logic                             m_axis_tlast,
    // line limit register
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [rla_pkg::LIMIT_W-1:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [rla_pkg::BYTE_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [rla_pkg::BYTE_W-1:0]  ram_rdata;
    rla_pkg::t_out_req           out_req;
    logic                        out_free;
    rla_pkg::t_result            out_res;

    assign o_cfg_ready = 1'b1;

    // byte store
    rla_ram #(
        .WIDTH (rla_pkg::BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // bookkeeping and line walker
    rla_walk #(
        .BUFFER_DEPTH   (BUFFER_DEPTH),
        .LINE_LIMIT_MAX (LINE_LIMIT_MAX)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_req       (out_req),
        .i_out_free  (out_free)
    );

    // result register
    rla_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (out_req),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = out_res.line_char;
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// File: rtl/rla_checker.sv
// ----------------------------------------------------------------------------
// rla_checker
// port-level checks of the receive line assembler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "receive_line_assembler_top_defines.svh"

module rla_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic [1:0] s_axis_tuser,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // a stalled result holds
    `RLA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // only done and no-line results close a take
    `RLA_ASSERT_SAME(a_last_kind, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tuser != rla_pkg::KIND_CHAR))

    // markers carry no character
    `RLA_ASSERT_SAME(a_marker_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != rla_pkg::KIND_CHAR), m_axis_tdata == 8'd0)

    // no result kind outside the three defined
    `RLA_ASSERT_SAME(a_kind_code, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tuser == rla_pkg::KIND_CHAR) || (m_axis_tuser == rla_pkg::KIND_DONE) || (m_axis_tuser == rla_pkg::KIND_NONE))

    // no input item is taken while a result is stalled
    `RLA_ASSERT_SAME(a_take_free, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid || m_axis_tready)

endmodule

bind receive_line_assembler_top rla_checker u_rla_checker (.*);

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for receive_line_assembler_top: a queue-fed stream
// driver applies append, clear and take-line items with random gaps, a
// predictor tracks the circular byte store and the line limit, and a monitor
// compares every result item with the oldest predicted one
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STORE_DEPTH = rla_pkg::BUFFER_DEPTH_DEF;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          QUIET_LIMIT = 4000;
    localparam int          SETTLE_CYC  = 8;

    typedef struct packed {
        logic [rla_pkg::OP_W-1:0]   op;
        logic [rla_pkg::BYTE_W-1:0] data;
    } t_rx_op;

    // dut ports
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata = '0;   // [7:0] data_byte
    logic [1:0]                    s_axis_tuser = '0;   // [1:0] operation
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [7:0]                    m_axis_tdata;        // [7:0] line_char
    logic [1:0]                    m_axis_tuser;        // [1:0] kind
    logic                          m_axis_tlast;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [rla_pkg::LIMIT_W-1:0]   i_cfg_data = '0;

    // stimulus and expectation stores
    t_rx_op           rx_ops_q[$];
    rla_pkg::t_result line_out_q[$];
    int               err_cnt = 0;
    int               stim_cnt = 0;

    // predictor state
    logic [rla_pkg::BYTE_W-1:0]  held_bytes [STORE_DEPTH];
    int                          held_cnt = 0;
    int                          head_idx = 0;
    logic [rla_pkg::LIMIT_W-1:0] line_lim = rla_pkg::LINE_LIMIT_RESET;

    // handshake history and idling state
    logic in_took = 1'b0;
    logic out_took = 1'b0;
    int   in_gap = 0;
    int   out_stall = 0;
    bit   calm_in = 1'b0;
    bit   calm_out = 1'b0;
    int   quiet_cnt = 0;

    receive_line_assembler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_brk(logic [rla_pkg::BYTE_W-1:0] b);
        return (b == rla_pkg::CHAR_CR) || (b == rla_pkg::CHAR_LF);
    endfunction

    function automatic int pick_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, 17));
    endfunction

    function automatic void push_result(logic [rla_pkg::KIND_W-1:0] k,
                                        logic [rla_pkg::BYTE_W-1:0] c, logic l);
        rla_pkg::t_result r;
        r.kind      = k;
        r.line_char = c;
        r.last      = l;
        line_out_q.push_back(r);
    endfunction

    // predicted results of one take-line request
    function automatic void predict_take();
        int                         eff;
        int                         i;
        int                         emitted;
        bit                         found;
        bit                         started;
        bit                         ended;
        logic [rla_pkg::BYTE_W-1:0] b;
        eff = (line_lim > rla_pkg::LINE_LIMIT_MAX_DEF) ? rla_pkg::LINE_LIMIT_MAX_DEF
                                                        : int'(line_lim);
        found = 1'b0;
        for (i = 0; i < held_cnt; i++) begin
            if (is_brk(held_bytes[(head_idx + i) % STORE_DEPTH]))
                found = 1'b1;
        end
        if (eff == 0 || held_cnt == 0 || !(found || held_cnt == STORE_DEPTH)) begin
            push_result(rla_pkg::KIND_NONE, 8'h00, 1'b1);
            return;
        end
        emitted = 0;
        started = 1'b0;
        ended   = 1'b0;
        for (i = 0; i < held_cnt; i++) begin
            b = held_bytes[(head_idx + i) % STORE_DEPTH];
            if (is_brk(b)) begin
                if (started)
                    ended = 1'b1;
            end else begin
                if (ended)
                    break;
                started = 1'b1;
                if (emitted + 1 < eff) begin
                    push_result(rla_pkg::KIND_CHAR, b, 1'b0);
                    emitted++;
                end
            end
        end
        push_result(rla_pkg::KIND_DONE, 8'h00, 1'b1);
        head_idx = (head_idx + i) % STORE_DEPTH;
        held_cnt = held_cnt - i;
        if (held_cnt == 0)
            head_idx = 0;
    endfunction

    // predictor step for one accepted item
    function automatic void apply_rx_op(logic [rla_pkg::OP_W-1:0] op,
                                        logic [rla_pkg::BYTE_W-1:0] data);
        case (op)
            rla_pkg::OP_APPEND: begin
                if (held_cnt < STORE_DEPTH) begin
                    held_bytes[(head_idx + held_cnt) % STORE_DEPTH] = data;
                    held_cnt++;
                end
            end
            rla_pkg::OP_CLEAR: begin
                held_cnt = 0;
                head_idx = 0;
            end
            rla_pkg::OP_TAKE: predict_take();
            default: ;
        endcase
    endfunction

    // sampling at the rising edge: predictor update and result check
    always @(posedge i_clk) begin
        rla_pkg::t_result want;
        in_took  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_took <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (line_out_q.size() == 0) begin
                    $error("unexpected result item kind=%0d char=%02h last=%0d",
                           m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    err_cnt++;
                end else begin
                    want = line_out_q.pop_front();
                    if (m_axis_tuser !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                        err_cnt++;
                    end
                    if (m_axis_tdata !== want.line_char) begin
                        $error("line_char: expected %02h, got %02h",
                               want.line_char, m_axis_tdata);
                        err_cnt++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                line_lim = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                apply_rx_op(s_axis_tuser, s_axis_tdata);
        end
    end

    // input driver, fed from the pending item queue
    always @(negedge i_clk) begin
        t_rx_op itm;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_took) begin
            if (in_gap > 0) begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (rx_ops_q.size() != 0) begin
                itm = rx_ops_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= itm.data;
                s_axis_tuser  <= itm.op;
                if ($urandom_range(0, 39) == 0)
                    calm_in = !calm_in;
                in_gap = pick_wait(calm_in);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side ready, with a random stall drawn after each accepted item
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (out_took) begin
                if ($urandom_range(0, 39) == 0)
                    calm_out = !calm_out;
                out_stall = pick_wait(calm_out);
            end
            if (out_stall > 0) begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with work outstanding and no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cnt <= 0;
        end else if (rx_ops_q.size() != 0 || s_axis_tvalid || line_out_q.size() != 0 ||
                     i_cfg_valid) begin
            quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt >= QUIET_LIMIT) begin
                $display("[receive_line_assembler_top] ERROR");
                $finish;
            end
        end
    end

    function automatic void push_op(logic [rla_pkg::OP_W-1:0] op,
                                    logic [rla_pkg::BYTE_W-1:0] data);
        t_rx_op itm;
        itm.op   = op;
        itm.data = data;
        rx_ops_q.push_back(itm);
        if (op != OP_UNUSED)
            stim_cnt++;
    endfunction

    function automatic logic [rla_pkg::BYTE_W-1:0] pick_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [rla_pkg::BYTE_W-1:0] pick_plain_char();
        logic [rla_pkg::BYTE_W-1:0] b;
        do
            b = pick_byte();
        while (is_brk(b));
        return b;
    endfunction

    function automatic logic [rla_pkg::BYTE_W-1:0] pick_break();
        return $urandom_range(0, 1) ? rla_pkg::CHAR_CR : rla_pkg::CHAR_LF;
    endfunction

    // one random chunk: mostly a well-formed line, otherwise noise
    function automatic void queue_random_chunk();
        int r;
        int len;
        int n;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                              : $urandom_range(0, 12);
            for (n = 0; n < len; n++)
                push_op(rla_pkg::OP_APPEND, pick_plain_char());
            len = $urandom_range(1, 3);
            for (n = 0; n < len; n++)
                push_op(rla_pkg::OP_APPEND, pick_break());
            if ($urandom_range(0, 3) != 0)
                push_op(rla_pkg::OP_TAKE, pick_byte());
        end else if (r < 85) begin
            push_op(rla_pkg::OP_APPEND, pick_byte());
        end else if (r < 92) begin
            push_op(rla_pkg::OP_TAKE, pick_byte());
        end else if (r < 96) begin
            push_op(rla_pkg::OP_CLEAR, pick_byte());
        end else begin
            push_op(OP_UNUSED, pick_byte());
        end
    endfunction

    // fill the store with one short line in front, take it, refill past the
    // wrap point until full with no break held, then take the whole store
    function automatic void queue_full_store();
        int n;
        push_op(rla_pkg::OP_CLEAR, 8'h00);
        push_op(rla_pkg::OP_APPEND, pick_plain_char());
        push_op(rla_pkg::OP_APPEND, pick_plain_char());
        push_op(rla_pkg::OP_APPEND, pick_break());
        for (n = 3; n < STORE_DEPTH + 1; n++)
            push_op(rla_pkg::OP_APPEND, pick_plain_char());
        push_op(rla_pkg::OP_TAKE, 8'h00);
        for (n = 0; n < 4; n++)
            push_op(rla_pkg::OP_APPEND, pick_plain_char());
        push_op(rla_pkg::OP_TAKE, 8'h00);
        push_op(rla_pkg::OP_TAKE, 8'h00);
    endfunction

    // wait until all items are in and all results are out
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (rx_ops_q.size() != 0 || s_axis_tvalid || line_out_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [rla_pkg::LIMIT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stimulus sequence
    initial begin
        logic [rla_pkg::LIMIT_W-1:0] lims [6];
        int ph;
        int goal;
        lims = '{7'd1, 7'd127, 7'd5, 7'd0, 7'd65, 7'd33};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, ignored code, line without break
        push_op(rla_pkg::OP_TAKE, 8'h00);
        push_op(OP_UNUSED, 8'hFF);
        push_op(rla_pkg::OP_APPEND, 8'h41);
        push_op(rla_pkg::OP_APPEND, 8'h00);
        push_op(rla_pkg::OP_APPEND, 8'hFF);
        push_op(rla_pkg::OP_TAKE, 8'hFF);
        // break arrives, line is handed out
        push_op(rla_pkg::OP_APPEND, rla_pkg::CHAR_CR);
        push_op(rla_pkg::OP_APPEND, rla_pkg::CHAR_LF);
        push_op(rla_pkg::OP_TAKE, 8'h00);
        // leading breaks skipped, trailing char kept
        push_op(rla_pkg::OP_APPEND, rla_pkg::CHAR_LF);
        push_op(rla_pkg::OP_APPEND, rla_pkg::CHAR_CR);
        push_op(rla_pkg::OP_APPEND, 8'h78);
        push_op(rla_pkg::OP_APPEND, 8'h79);
        push_op(rla_pkg::OP_APPEND, rla_pkg::CHAR_CR);
        push_op(rla_pkg::OP_APPEND, 8'h7A);
        push_op(rla_pkg::OP_TAKE, 8'h00);
        push_op(rla_pkg::OP_TAKE, 8'h00);
        // clear, then breaks only
        push_op(rla_pkg::OP_CLEAR, 8'hA5);
        push_op(rla_pkg::OP_TAKE, 8'h00);
        push_op(rla_pkg::OP_APPEND, rla_pkg::CHAR_CR);
        push_op(rla_pkg::OP_APPEND, rla_pkg::CHAR_LF);
        push_op(rla_pkg::OP_TAKE, 8'h00);
        wait_idle();

        // limit of one: done marker only, line consumed
        write_limit(7'd1);
        push_op(rla_pkg::OP_APPEND, 8'h61);
        push_op(rla_pkg::OP_APPEND, 8'h62);
        push_op(rla_pkg::OP_APPEND, rla_pkg::CHAR_LF);
        push_op(rla_pkg::OP_TAKE, 8'h00);
        wait_idle();
        // zero limit: no line, store untouched
        write_limit(7'd0);
        push_op(rla_pkg::OP_APPEND, 8'h63);
        push_op(rla_pkg::OP_APPEND, rla_pkg::CHAR_LF);
        push_op(rla_pkg::OP_TAKE, 8'h00);
        wait_idle();
        write_limit(7'd2);
        push_op(rla_pkg::OP_TAKE, 8'h00);
        wait_idle();

        // random phases over several limits
        for (ph = 0; ph < 6; ph++) begin
            write_limit(lims[ph]);
            if (ph == 1)
                queue_full_store();
            goal = stim_cnt + 1;
            while (stim_cnt < goal)
                queue_random_chunk();
            push_op(rla_pkg::OP_APPEND, rla_pkg::CHAR_LF);
            push_op(rla_pkg::OP_TAKE, 8'h00);
            wait_idle();
        end

        if (err_cnt == 0)
            $display("[receive_line_assembler_top] OK");
        else
            $display("[receive_line_assembler_top] ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/rla_pkg.sv
rtl/rla_ram.sv
rtl/rla_walk.sv
rtl/rla_out_reg.sv
rtl/receive_line_assembler_top.sv
rtl/rla_checker.sv
bench/tb.sv
